// ===== hdl/hashed_address_set_core_macros.svh =====
// Assertion macros shared by the checker of the hashed address set core.
`ifndef HASHED_ADDRESS_SET_CORE_MACROS_SVH
`define HASHED_ADDRESS_SET_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define HSET_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("hashed_address_set_core: check failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define HSET_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("hashed_address_set_core: check failed");

`endif

// ===== hdl/hset_pkg.sv =====
// Shared types, constants and helpers of the hashed address set core.
package hset_pkg;

   localparam int TABLE_SLOTS_DEF      = 1024;
   localparam int PROBE_LIMIT_DEF      = 64;
   localparam int RANGE_SLOT_LIMIT_DEF = 4096;

   localparam int CNT_W      = 32;
   localparam int SLOT_BYTES = 8;

   localparam logic [63:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B = 64'h94d049bb133111eb;
   localparam int MIX_SHIFT_A = 30;
   localparam int MIX_SHIFT_B = 27;
   localparam int MIX_SHIFT_C = 31;

   localparam logic OP_NOTE     = 1'b0;
   localparam logic OP_CONTAINS = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [63:0] address;
      logic [31:0] length;
   } req_data_type;

   typedef struct packed {
      logic             hit;
      logic [CNT_W-1:0] note_count;
      logic [CNT_W-1:0] inserted_count;
      logic [CNT_W-1:0] dropped_count;
      logic [CNT_W-1:0] hit_count;
      logic [CNT_W-1:0] miss_count;
   } rsp_data_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] value);
      sat_inc = (&value) ? value : value + CNT_W'(1);
   endfunction

endpackage

// ===== hdl/hset_mix.sv =====
// Iterative 64-bit mix hash: one shared 32x32 multiplier, four passes per product.
module hset_mix #(
   parameter int IDX_W = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [63:0]      key,
   output logic             done,
   output logic [IDX_W-1:0] index
);

   typedef enum logic [1:0] {M_IDLE, M_MUL1, M_MUL2} mix_state_type;

   mix_state_type state_ff;
   logic [1:0]    phase_ff;
   logic [63:0]   x_ff;
   logic [63:0]   acc_ff;
   logic [63:0]   prod_ff;
   logic          done_ff;

   logic [63:0] mul_const;
   logic [31:0] op_a;
   logic [31:0] op_b;
   logic [63:0] prod_in;
   logic [63:0] acc_in;

   // Low 64 bits of x * C: lo*lo + ((hi*lo + lo*hi) << 32)
   always_comb begin
      mul_const = (state_ff == M_MUL2) ? hset_pkg::MIX_MUL_B : hset_pkg::MIX_MUL_A;
      op_a      = (phase_ff == 2'd1) ? x_ff[63:32] : x_ff[31:0];
      op_b      = (phase_ff == 2'd2) ? mul_const[63:32] : mul_const[31:0];
      prod_in   = {32'd0, op_a} * {32'd0, op_b};
      acc_in    = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         phase_ff <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            M_IDLE: begin
               if (start) begin
                  x_ff     <= key ^ (key >> hset_pkg::MIX_SHIFT_A);
                  phase_ff <= 2'd0;
                  state_ff <= M_MUL1;
               end
            end
            M_MUL1, M_MUL2: begin
               prod_ff  <= prod_in;
               phase_ff <= phase_ff + 2'd1;
               if (phase_ff == 2'd1) begin
                  acc_ff <= prod_ff;
               end else if (phase_ff == 2'd2) begin
                  acc_ff <= acc_in;
               end else if (phase_ff == 2'd3) begin
                  if (state_ff == M_MUL1) begin
                     x_ff     <= acc_in ^ (acc_in >> hset_pkg::MIX_SHIFT_B);
                     state_ff <= M_MUL2;
                  end else begin
                     x_ff     <= acc_in ^ (acc_in >> hset_pkg::MIX_SHIFT_C);
                     done_ff  <= 1'b1;
                     state_ff <= M_IDLE;
                  end
               end
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign done  = done_ff;
   assign index = x_ff[IDX_W-1:0];

endmodule

// ===== hdl/hset_table.sv =====
// Slot store: one write port, one registered read port.
module hset_table #(
   parameter int IDX_W = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [63:0]      wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [63:0]      rd_data
);

   logic [63:0] mem_ff [2**IDX_W];
   logic [63:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/hashed_address_set_core.sv =====
// Top level of the hashed address set core: sequencer, counters and ports.
//
// Requests enter on start/req_data and are taken at an edge where start is high and
// busy is low. Each request gives exactly one response: rsp_valid is high for one
// cycle with rsp_data (hit flag and the five saturating counters after the request).
// The receiver cannot stall; the response is gone after that cycle. The enable
// register is written over csr_valid/csr_ready/csr_data; csr_ready is always high.
//
// After reset the block sweeps the slot store to empty, one entry a cycle, with busy
// high; enable writes still land.
//
// From the accepting edge to the edge that raises rsp_valid: a key hash runs on the
// shared 32x32 multiplier (four passes for each of the two 64-bit products); each
// probe then does a registered store read and a compare. A lookup makes at most
// PROBE_LIMIT probes. A range request first finds its span, then hashes and probes
// each slot, up to RANGE_SLOT_LIMIT slots. Ignored or disabled requests answer from
// the decode state, a range that holds no whole slot from the span state.
// A new request can be taken in the cycle its predecessor's response is shown.
module hashed_address_set_core #(
   parameter int TABLE_SLOTS      = hset_pkg::TABLE_SLOTS_DEF,
   parameter int PROBE_LIMIT      = hset_pkg::PROBE_LIMIT_DEF,
   parameter int RANGE_SLOT_LIMIT = hset_pkg::RANGE_SLOT_LIMIT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  hset_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   output hset_pkg::rsp_data_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_data
);

   localparam int IDX_W   = $clog2(TABLE_SLOTS);
   localparam int PW      = $clog2(PROBE_LIMIT + 1);
   localparam int CW      = $clog2(RANGE_SLOT_LIMIT + 1);
   localparam int SH      = $clog2(hset_pkg::SLOT_BYTES);
   localparam int CNT_W   = hset_pkg::CNT_W;
   localparam logic [PW-1:0] PROBE_LAST = PW'(PROBE_LIMIT - 1);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_SPAN, S_HASH, S_RD, S_CMP
   } seq_state_type;

   seq_state_type    state_ff;
   logic [IDX_W-1:0] clr_idx_ff;
   logic             enabled_ff;
   logic             op_ff;
   logic [63:0]      addr_ff;
   logic [31:0]      len_ff;
   logic [63:0]      key_ff;
   logic [63:0]      first_ff;
   logic [64:0]      end_ff;
   logic [CW-1:0]    slots_left_ff;
   logic [IDX_W-1:0] pos_ff;
   logic [PW-1:0]    probe_ff;
   logic             hit_ff;
   logic             mix_start_ff;
   logic             rsp_valid_ff;
   logic [CNT_W-1:0] notes_ff;
   logic [CNT_W-1:0] stored_ff;
   logic [CNT_W-1:0] dropped_ff;
   logic [CNT_W-1:0] hits_ff;
   logic [CNT_W-1:0] misses_ff;

   logic [63:0]      round_sum;
   logic [64:0]      span_sum;
   logic [64:0]      end_in;
   logic [65:0]      span_diff;
   logic [61:0]      slots_raw;
   logic [CW-1:0]    slots_in;
   logic             top_start;
   logic             mix_done;
   logic [IDX_W-1:0] mix_index;
   logic [63:0]      rd_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [63:0]      wr_data;
   logic             slot_empty;
   logic             slot_match;

   always_comb begin
      round_sum = addr_ff + 64'(hset_pkg::SLOT_BYTES - 1);
      span_sum  = {1'b0, addr_ff} + {33'd0, len_ff};
      // range running past the top of the address space stops at 2^64
      end_in    = span_sum[64] ? {1'b1, 64'd0} : span_sum;
      top_start = (&addr_ff[63:SH]) && (addr_ff[SH-1:0] != '0);
      span_diff = {1'b0, end_ff} - {2'b00, first_ff};
      slots_raw = span_diff[64:SH];
      slots_in  = (slots_raw > 62'(RANGE_SLOT_LIMIT)) ? CW'(RANGE_SLOT_LIMIT)
                                                       : CW'(slots_raw);
      slot_empty = (rd_data == 64'd0);
      slot_match = (rd_data == key_ff);
      wr_en   = (state_ff == S_CLEAR) ||
                (state_ff == S_CMP && op_ff == hset_pkg::OP_NOTE && slot_empty);
      wr_addr = (state_ff == S_CLEAR) ? clr_idx_ff : pos_ff;
      wr_data = (state_ff == S_CLEAR) ? 64'd0 : key_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         enabled_ff   <= 1'b0;
         mix_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         notes_ff     <= '0;
         stored_ff    <= '0;
         dropped_ff   <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
      end else begin
         mix_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         if (csr_valid && csr_ready) begin
            enabled_ff <= csr_data;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_idx_ff <= clr_idx_ff + IDX_W'(1);
               if (&clr_idx_ff) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  op_ff    <= req_data.operation;
                  addr_ff  <= req_data.address;
                  len_ff   <= req_data.length;
                  hit_ff   <= 1'b0;
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               if (!enabled_ff) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else if (op_ff == hset_pkg::OP_CONTAINS) begin
                  if (addr_ff == 64'd0) begin
                     misses_ff    <= hset_pkg::sat_inc(misses_ff);
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     key_ff       <= addr_ff;
                     mix_start_ff <= 1'b1;
                     state_ff     <= S_HASH;
                  end
               end else if (addr_ff == 64'd0 || len_ff == 32'd0) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  notes_ff <= hset_pkg::sat_inc(notes_ff);
                  if (top_start) begin
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     first_ff <= {round_sum[63:SH], {SH{1'b0}}};
                     end_ff   <= end_in;
                     state_ff <= S_SPAN;
                  end
               end
            end
            S_SPAN: begin
               if (span_diff[65] || slots_in == '0) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  slots_left_ff <= slots_in;
                  key_ff        <= first_ff;
                  mix_start_ff  <= 1'b1;
                  state_ff      <= S_HASH;
               end
            end
            S_HASH: begin
               if (mix_done) begin
                  pos_ff   <= mix_index;
                  probe_ff <= '0;
                  state_ff <= S_RD;
               end
            end
            S_RD: begin
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (op_ff == hset_pkg::OP_NOTE) begin
                  if (slot_match || slot_empty || probe_ff == PROBE_LAST) begin
                     if (slot_empty) begin
                        stored_ff <= hset_pkg::sat_inc(stored_ff);
                     end else if (!slot_match) begin
                        dropped_ff <= hset_pkg::sat_inc(dropped_ff);
                     end
                     if (slots_left_ff == CW'(1)) begin
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_IDLE;
                     end else begin
                        slots_left_ff <= slots_left_ff - CW'(1);
                        key_ff        <= key_ff + 64'(hset_pkg::SLOT_BYTES);
                        mix_start_ff  <= 1'b1;
                        state_ff      <= S_HASH;
                     end
                  end else begin
                     probe_ff <= probe_ff + PW'(1);
                     pos_ff   <= pos_ff + IDX_W'(1);
                     state_ff <= S_RD;
                  end
               end else begin
                  if (slot_match) begin
                     hit_ff       <= 1'b1;
                     hits_ff      <= hset_pkg::sat_inc(hits_ff);
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else if (slot_empty || probe_ff == PROBE_LAST) begin
                     misses_ff    <= hset_pkg::sat_inc(misses_ff);
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end else begin
                     probe_ff <= probe_ff + PW'(1);
                     pos_ff   <= pos_ff + IDX_W'(1);
                     state_ff <= S_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   hset_mix #(
      .IDX_W (IDX_W)
   ) u_mix (
      .clock (clock),
      .reset (reset),
      .start (mix_start_ff),
      .key   (key_ff),
      .done  (mix_done),
      .index (mix_index)
   );

   hset_table #(
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   assign rsp_data.hit            = hit_ff;
   assign rsp_data.note_count     = notes_ff;
   assign rsp_data.inserted_count = stored_ff;
   assign rsp_data.dropped_count  = dropped_ff;
   assign rsp_data.hit_count      = hits_ff;
   assign rsp_data.miss_count     = misses_ff;

endmodule

// ===== hdl/hset_checker.sv =====
// Port-level checks of the hashed address set core, bound to the top level.
`include "hashed_address_set_core_macros.svh"

module hset_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input hset_pkg::rsp_data_type rsp_data
);

   // store sweep follows reset
   `HSET_ASSERT_NOW(a_clear_after_reset, $fell(reset), busy)
   // an accepted request raises busy
   `HSET_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
   // a response is shown only once the sequencer is back to idle
   `HSET_ASSERT_NOW(a_rsp_when_idle, rsp_valid, !busy)
   // a hit is always counted
   `HSET_ASSERT_NOW(a_hit_counted, rsp_valid && rsp_data.hit, rsp_data.hit_count != '0)

endmodule

bind hashed_address_set_core hset_checker u_hset_checker (.*);
